[design/assert_macros.svh]
// Assertion macros shared by the classifier RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on the rising clock, off while reset is asserted.
`define ASSERT_ON(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("classifier assertion failed");

// Condition that must never be true at a sampled edge.
`define ASSERT_NEVER(lbl, clk, rstn, cond) `ASSERT_ON(lbl, clk, rstn, !(cond))

`endif

[design/wssc_pkg.sv]
// Shared types, constants and signature tables of the scan classifier.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
`default_nettype none

package wssc_pkg;

	localparam int WINDOW_BYTES = 17;
	localparam int SIG_COUNT    = 17;
	localparam int SIG_MAX_LEN  = 17;
	localparam int SIG_BITS     = SIG_MAX_LEN * 8;
	localparam int WIN_BITS     = WINDOW_BYTES * 8;
	localparam int HIST_BITS    = (WINDOW_BYTES - 1) * 8;
	localparam int LEN_W        = 5;
	localparam int WEIGHT_W     = 3;
	localparam int SCORE_W      = 6;
	localparam int VK_W         = 5;
	localparam int GL_W         = 4;
	localparam int CFG_W        = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	typedef logic [SIG_BITS-1:0]  sig_text_t;
	typedef logic [SIG_COUNT-1:0] hits_t;
	typedef logic [SCORE_W-1:0]   score_t;
	typedef logic [CFG_W-1:0]     cfg_word_t;

	typedef enum logic [1:0] {
		FAM_NONE = 2'd0,
		FAM_D3D  = 2'd1,
		FAM_VK   = 2'd2,
		FAM_GL   = 2'd3
	} family_t;

	typedef enum logic [2:0] {
		API_UNKNOWN = 3'd0,
		API_D3D9    = 3'd1,
		API_D3D10   = 3'd2,
		API_D3D11   = 3'd3,
		API_D3D12   = 3'd4,
		API_VULKAN  = 3'd5,
		API_OPENGL  = 3'd6
	} api_t;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MARGIN = 2'd1;

	localparam cfg_word_t MIN_SCORE_RESET  = 6'd4;
	localparam cfg_word_t MIN_MARGIN_RESET = 6'd3;

	// Signatures that decide the d3d version.
	localparam int SIG_D3D12_DLL   = 0;
	localparam int SIG_D3D12_DEV   = 1;
	localparam int SIG_D3D11_DLL   = 2;
	localparam int SIG_D3D11_DEV   = 3;
	localparam int SIG_D3D10_1_DLL = 4;
	localparam int SIG_D3D10_DLL   = 5;
	localparam int SIG_D3D9_DLL    = 6;
	localparam int SIG_D3D_CREATE9 = 7;

	// Text is right aligned: the last character sits in the low byte.
	localparam sig_text_t SIG_TEXT [SIG_COUNT] = '{
		"d3d12.dll", "d3d12createdevice", "d3d11.dll", "d3d11createdevice",
		"d3d10_1.dll", "d3d10.dll", "d3d9.dll", "direct3dcreate9", "dxgi.dll",
		"vulkan-1.dll", "vkcreateinstance", "vkcreatedevice", "vkqueuepresentkhr",
		"opengl32.dll", "wglcreatecontext", "glgetstring", "wglgetprocaddress"
	};

	localparam logic [LEN_W-1:0] SIG_LEN [SIG_COUNT] = '{
		5'd9, 5'd17, 5'd9, 5'd17, 5'd11, 5'd9, 5'd8, 5'd15, 5'd8,
		5'd12, 5'd16, 5'd14, 5'd17,
		5'd12, 5'd16, 5'd11, 5'd17
	};

	localparam logic [WEIGHT_W-1:0] SIG_WEIGHT [SIG_COUNT] = '{
		3'd5, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd6, 3'd4, 3'd4, 3'd2,
		3'd6, 3'd4, 3'd2, 3'd2
	};

	localparam family_t SIG_FAMILY [SIG_COUNT] = '{
		FAM_D3D, FAM_D3D, FAM_D3D, FAM_D3D, FAM_D3D, FAM_D3D, FAM_D3D, FAM_D3D,
		FAM_D3D, FAM_VK, FAM_VK, FAM_VK, FAM_VK, FAM_GL, FAM_GL, FAM_GL, FAM_GL
	};

	typedef struct packed {
		logic  valid;
		hits_t hits;
	} hits_msg_t;

	typedef struct packed {
		cfg_word_t min_score;
		cfg_word_t min_margin;
	} cfg_t;

	typedef struct packed {
		api_t            api_code;
		family_t         family_code;
		score_t          pick_score;
		score_t          d3d_score;
		logic [VK_W-1:0] vk_score;
		logic [GL_W-1:0] gl_score;
	} result_t;

	// Byte mask that covers the low len bytes of a signature slot.
	function automatic sig_text_t sig_mask(input logic [LEN_W-1:0] len);
		sig_text_t m;
		m = '0;
		for (int b = 0; b < SIG_MAX_LEN; b++) begin
			if (b < int'(len)) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

[design/wssc_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on wssc_pkg for the result field types.
`default_nettype none

interface wssc_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface wssc_result_if;
	logic                           valid;
	logic                           ready;
	wssc_pkg::api_t                 api_code;
	wssc_pkg::family_t              family_code;
	wssc_pkg::score_t               pick_score;
	wssc_pkg::score_t               d3d_score;
	logic [wssc_pkg::VK_W-1:0]      vk_score;
	logic [wssc_pkg::GL_W-1:0]      gl_score;

	modport source(output valid, api_code, family_code, pick_score, d3d_score, vk_score,
		gl_score, input ready);
	modport sink(input valid, api_code, family_code, pick_score, d3d_score, vk_score,
		gl_score, output ready);
endinterface

`default_nettype wire

[design/wssc_front.sv]
// Front end: byte window, parallel signature compare and sticky found bits.
// Depends on wssc_pkg and wssc_scan_if; feeds wssc_queue.
`default_nettype none

module wssc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	wssc_scan_if.sink           scan,
	input  wire logic           q_full,
	output wssc_pkg::hits_msg_t push
);

	logic [wssc_pkg::HIST_BITS-1:0] window_q;
	wssc_pkg::hits_t                found_q;
	logic [wssc_pkg::WIN_BITS-1:0]  win_all;
	wssc_pkg::hits_t                match;
	wssc_pkg::hits_t                hits;
	logic                           accept;

	assign scan.ready = !q_full;
	assign accept     = scan.valid && scan.ready;

	// The current byte is the newest and sits in the low byte of the window.
	always_comb begin
		win_all = {window_q, scan.data_byte};
		for (int i = 0; i < wssc_pkg::SIG_COUNT; i++) begin
			match[i] = ((win_all[wssc_pkg::SIG_BITS-1:0] ^ wssc_pkg::SIG_TEXT[i])
				& wssc_pkg::sig_mask(wssc_pkg::SIG_LEN[i])) == '0;
		end
		hits = found_q | match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			found_q  <= '0;
		end else if (accept) begin
			if (scan.last_byte) begin
				window_q <= '0;
				found_q  <= '0;
			end else begin
				window_q <= win_all[wssc_pkg::HIST_BITS-1:0];
				found_q  <= hits;
			end
		end
	end

	assign push.valid = accept && scan.last_byte;
	assign push.hits  = hits;

endmodule

`default_nettype wire

[design/wssc_queue.sv]
// Short FIFO of finished found-bit sets between the front and back ends.
// Depends on wssc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wssc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wssc_pkg::hits_msg_t push,
	input  wire logic                pop,
	output logic                     full,
	output wssc_pkg::hits_msg_t      head
);

	wssc_pkg::hits_t                   entry_q [wssc_pkg::QUEUE_DEPTH];
	logic [wssc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [wssc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [wssc_pkg::QUEUE_CNT_W-1:0]  count_q;
	logic                              push_fire;
	logic                              pop_fire;

	localparam logic [wssc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
		wssc_pkg::QUEUE_PTR_W'(wssc_pkg::QUEUE_DEPTH - 1);
	localparam logic [wssc_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
		wssc_pkg::QUEUE_CNT_W'(wssc_pkg::QUEUE_DEPTH);

	assign full      = count_q == FULL_COUNT;
	assign push_fire = push.valid && !full;
	assign pop_fire  = pop && (count_q != '0);

	assign head.valid = count_q != '0;
	assign head.hits  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push.hits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > FULL_COUNT)
	`ASSERT_ON(a_count_grows, clk, arst_n, push_fire && !pop_fire |=> count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

[design/wssc_back.sv]
// Back end: family scores and d3d version, then ranking, pick and result register.
// Depends on wssc_pkg, wssc_result_if and assert_macros.svh; drains wssc_queue.
`default_nettype none

`include "assert_macros.svh"

module wssc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wssc_pkg::hits_msg_t head,
	output logic                     pop,
	input  wire wssc_pkg::cfg_t      cfg,
	wssc_result_if.source            result
);

	logic              valid_s1;
	wssc_pkg::score_t  d3d_s1;
	wssc_pkg::score_t  vk_s1;
	wssc_pkg::score_t  gl_s1;
	wssc_pkg::api_t    ver_s1;
	logic              valid_s2;
	wssc_pkg::result_t res_s2;

	wssc_pkg::score_t  d3d_sum;
	wssc_pkg::score_t  vk_sum;
	wssc_pkg::score_t  gl_sum;
	wssc_pkg::api_t    ver;
	wssc_pkg::family_t top_fam;
	wssc_pkg::score_t  top;
	wssc_pkg::score_t  second;
	wssc_pkg::score_t  mn_dv;
	wssc_pkg::score_t  mx_dv;
	wssc_pkg::score_t  mn_g;
	logic              pick_ok;
	wssc_pkg::result_t res;
	logic              advance_s2;
	logic              load_s1;
	logic              out_picked;
	logic              out_blank;

	assign advance_s2 = !valid_s2 || result.ready;
	assign load_s1    = !valid_s1 || advance_s2;
	assign pop        = load_s1 && head.valid;

	always_comb begin
		d3d_sum = '0;
		vk_sum  = '0;
		gl_sum  = '0;
		for (int i = 0; i < wssc_pkg::SIG_COUNT; i++) begin
			if (head.hits[i]) begin
				case (wssc_pkg::SIG_FAMILY[i])
					wssc_pkg::FAM_D3D: d3d_sum = d3d_sum + wssc_pkg::score_t'(wssc_pkg::SIG_WEIGHT[i]);
					wssc_pkg::FAM_VK:  vk_sum  = vk_sum + wssc_pkg::score_t'(wssc_pkg::SIG_WEIGHT[i]);
					wssc_pkg::FAM_GL:  gl_sum  = gl_sum + wssc_pkg::score_t'(wssc_pkg::SIG_WEIGHT[i]);
					default: ;
				endcase
			end
		end

		// Newest d3d version wins when several are present.
		if (head.hits[wssc_pkg::SIG_D3D12_DEV] || head.hits[wssc_pkg::SIG_D3D12_DLL]) begin
			ver = wssc_pkg::API_D3D12;
		end else if (head.hits[wssc_pkg::SIG_D3D11_DEV]
			|| head.hits[wssc_pkg::SIG_D3D11_DLL]) begin
			ver = wssc_pkg::API_D3D11;
		end else if (head.hits[wssc_pkg::SIG_D3D10_1_DLL]
			|| head.hits[wssc_pkg::SIG_D3D10_DLL]) begin
			ver = wssc_pkg::API_D3D10;
		end else if (head.hits[wssc_pkg::SIG_D3D_CREATE9]
			|| head.hits[wssc_pkg::SIG_D3D9_DLL]) begin
			ver = wssc_pkg::API_D3D9;
		end else begin
			ver = wssc_pkg::API_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			d3d_s1 <= d3d_sum;
			vk_s1  <= vk_sum;
			gl_s1  <= gl_sum;
			ver_s1 <= ver;
		end
	end

	// Ties keep the order d3d, vulkan, opengl; the runner-up is the median score.
	always_comb begin
		if (d3d_s1 >= vk_s1 && d3d_s1 >= gl_s1) begin
			top_fam = wssc_pkg::FAM_D3D;
			top     = d3d_s1;
		end else if (vk_s1 >= gl_s1) begin
			top_fam = wssc_pkg::FAM_VK;
			top     = vk_s1;
		end else begin
			top_fam = wssc_pkg::FAM_GL;
			top     = gl_s1;
		end
		mn_dv   = (d3d_s1 < vk_s1) ? d3d_s1 : vk_s1;
		mx_dv   = (d3d_s1 < vk_s1) ? vk_s1 : d3d_s1;
		mn_g    = (mx_dv < gl_s1) ? mx_dv : gl_s1;
		second  = (mn_dv < mn_g) ? mn_g : mn_dv;
		pick_ok = (top >= cfg.min_score)
			&& !((second != '0) && ((top - second) < cfg.min_margin));

		res.d3d_score = d3d_s1;
		res.vk_score  = vk_s1[wssc_pkg::VK_W-1:0];
		res.gl_score  = gl_s1[wssc_pkg::GL_W-1:0];
		if (pick_ok) begin
			res.family_code = top_fam;
			res.pick_score  = top;
		end else begin
			res.family_code = wssc_pkg::FAM_NONE;
			res.pick_score  = '0;
		end
		case (res.family_code)
			wssc_pkg::FAM_D3D: res.api_code = ver_s1;
			wssc_pkg::FAM_VK:  res.api_code = wssc_pkg::API_VULKAN;
			wssc_pkg::FAM_GL:  res.api_code = wssc_pkg::API_OPENGL;
			default:           res.api_code = wssc_pkg::API_UNKNOWN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign result.valid       = valid_s2;
	assign result.api_code    = res_s2.api_code;
	assign result.family_code = res_s2.family_code;
	assign result.pick_score  = res_s2.pick_score;
	assign result.d3d_score   = res_s2.d3d_score;
	assign result.vk_score    = res_s2.vk_score;
	assign result.gl_score    = res_s2.gl_score;

	assign out_picked = valid_s2 && (res_s2.family_code != wssc_pkg::FAM_NONE);
	assign out_blank  = (res_s2.api_code == wssc_pkg::API_UNKNOWN) && (res_s2.pick_score == '0);

	`ASSERT_ON(a_pick_meets_min, clk, arst_n, out_picked |-> res_s2.pick_score >= cfg.min_score)
	`ASSERT_ON(a_none_is_blank, clk, arst_n, valid_s2 && !out_picked |-> out_blank)

endmodule

`default_nettype wire

[design/weighted_signature_scan_classifier_unit.sv]
// Top level of the weighted signature scan classifier.
// Depends on wssc_pkg, wssc_if, wssc_front, wssc_queue and wssc_back.
`default_nettype none

// The block takes one lower-case content byte per cycle on the scan channel. A
// 17-byte window is compared against all 17 signatures in parallel in the front
// end, so a byte stream flows at one byte per cycle while the queue is not
// full. The byte flagged as last closes the stream: its found bits go into a
// two-entry queue and the front end starts the next stream on the following
// cycle. The back end scores, ranks and picks in two register stages, s1 and
// then the result register s2. If the result side stalls long enough for the
// queue to fill, scan.ready drops until an entry is drained. The configuration
// port writes min_score (index 0) and min_margin (index 1); other indexes are
// ignored. No clearing pass is needed after reset.
module weighted_signature_scan_classifier_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	wssc_scan_if.sink                           scan,
	wssc_result_if.source                       result,
	input  wire logic                           cfg_we,
	input  wire logic [wssc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wssc_pkg::CFG_W-1:0]     cfg_wdata
);

	wssc_pkg::cfg_t      cfg_q;
	wssc_pkg::hits_msg_t push;
	wssc_pkg::hits_msg_t head;
	logic                q_full;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_score  <= wssc_pkg::MIN_SCORE_RESET;
			cfg_q.min_margin <= wssc_pkg::MIN_MARGIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wssc_pkg::REG_MIN_SCORE:  cfg_q.min_score  <= cfg_wdata;
				wssc_pkg::REG_MIN_MARGIN: cfg_q.min_margin <= cfg_wdata;
				default: ;
			endcase
		end
	end

	wssc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan),
		.q_full (q_full),
		.push   (push)
	);

	wssc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	wssc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.cfg    (cfg_q),
		.result (result)
	);

endmodule

`default_nettype wire
